### hw/rtl/block_average_ascii_shader_macros.svh
// ----------------------------------------------------------------------------
// Block average ASCII shader assertion macros
// Shared assertion forms for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_ASCII_SHADER_MACROS_SVH
`define BLOCK_AVERAGE_ASCII_SHADER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// Block average ASCII shader package
// Field widths, register indexes, shade table and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

  // Fixed field widths.
  localparam int PIX_BITS     = 8;
  localparam int RGB_SUM_BITS = 10;
  localparam int CHAR_BITS    = 8;
  localparam int GREY_BITS    = 8;
  localparam int IMG_W_BITS   = 11;
  localparam int IMG_H_BITS   = 13;
  localparam int WIN_BITS     = 5;

  // Configuration port.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_IDX_BITS  = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WINDOW = 2'd2;

  localparam logic [IMG_W_BITS-1:0] RST_WIDTH  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RST_HEIGHT = 13'd480;
  localparam logic [WIN_BITS-1:0]   RST_WINDOW = 5'd8;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] NEWLINE = 8'd10;

  // Descending grey thresholds and their shade characters.
  localparam int N_SHADES = 9;
  localparam logic [GREY_BITS-1:0] GREY_LIMITS [N_SHADES] = '{
    8'd230, 8'd200, 8'd180, 8'd160, 8'd130, 8'd100, 8'd70, 8'd50, 8'd0
  };
  // ' ' . ' : o & 8 # @
  localparam logic [CHAR_BITS-1:0] SHADE_CHARS [N_SHADES] = '{
    8'h20, 8'h2E, 8'h27, 8'h3A, 8'h6F, 8'h26, 8'h38, 8'h23, 8'h40
  };

  typedef struct packed {
    logic [IMG_W_BITS-1:0] image_width;
    logic [IMG_H_BITS-1:0] image_height;
    logic [WIN_BITS-1:0]   window_size;
  } bas_cfg_t;

  // What a queued item asks the back part to emit.
  typedef struct packed {
    logic has_char;
    logic has_nl;
  } bas_flags_t;

  // First threshold that the grey level reaches picks the character.
  function automatic logic [CHAR_BITS-1:0] pick_shade(input logic [GREY_BITS-1:0] grey);
    logic [CHAR_BITS-1:0] r;
    logic                 found;
    r     = SHADE_CHARS[N_SHADES-1];
    found = 1'b0;
    for (int k = 0; k < N_SHADES; k++) begin
      if (!found && grey >= GREY_LIMITS[k]) begin
        r     = SHADE_CHARS[k];
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int unsigned clamp_window(input logic [WIN_BITS-1:0] v,
                                               input int unsigned max_win);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    if (r > max_win) r = max_win;
    return r;
  endfunction

  function automatic int unsigned clamp_width(input logic [IMG_W_BITS-1:0] v,
                                              input int unsigned max_wd);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    if (r > max_wd) r = max_wd;
    return r;
  endfunction

  function automatic logic [IMG_H_BITS-1:0] clamp_height(input logic [IMG_H_BITS-1:0] v);
    logic [IMG_H_BITS-1:0] r;
    r = v;
    if (r == '0) r = IMG_H_BITS'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bas_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file; any write to a listed register restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bas_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [bas_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [bas_pkg::APB_DATA_BITS-1:0]   prdata,
  output bas_pkg::bas_cfg_t                   cfg,
  output logic                                restart
);
  import bas_pkg::*;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr;

  assign idx = paddr[REG_IDX_BITS+1:2];
  assign wr  = psel && penable && pwrite;

  // A write to an index past the list does nothing.
  always_comb begin
    restart = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_WIDTH, REG_HEIGHT, REG_WINDOW: restart = 1'b1;
        default:                           restart = 1'b0;
      endcase
    end
  end

  // Register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_WIDTH;
      cfg.image_height <= RST_HEIGHT;
      cfg.window_size  <= RST_WINDOW;
    end else if (wr) begin
      unique case (idx)
        REG_WIDTH:  cfg.image_width  <= pwdata[IMG_W_BITS-1:0];
        REG_HEIGHT: cfg.image_height <= pwdata[IMG_H_BITS-1:0];
        REG_WINDOW: cfg.window_size  <= pwdata[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = APB_DATA_BITS'(cfg.image_width);
      REG_HEIGHT: prdata = APB_DATA_BITS'(cfg.image_height);
      REG_WINDOW: prdata = APB_DATA_BITS'(cfg.window_size);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/bas_front.sv
// ----------------------------------------------------------------------------
// Front part: pixel accumulation
// Tracks the raster position, adds each pixel into its tile column's sum and
// queues an item whenever a tile completes or a band ends.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 16,
  parameter int SUM_W      = $clog2(765 * MAX_WINDOW * MAX_WINDOW + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bas_pkg::bas_cfg_t              cfg,
  input  logic                           restart,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bas_pkg::PIX_BITS-1:0]   red,
  input  logic [bas_pkg::PIX_BITS-1:0]   green,
  input  logic [bas_pkg::PIX_BITS-1:0]   blue,
  input  logic [bas_pkg::Q_CNT_W-1:0]    q_count,
  output logic                           push,
  output bas_pkg::bas_flags_t            push_flags,
  output logic [SUM_W-1:0]               push_sum
);
  import bas_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int ROW_W = IMG_H_BITS;
  localparam int CB_W  = ((COL_W > WIN_W) ? COL_W : WIN_W) + 1;
  localparam int RB_W  = ((ROW_W > WIN_W) ? ROW_W : WIN_W) + 1;

  // Raster position.
  logic [COL_W-1:0] pixel_column;
  logic [ROW_W-1:0] pixel_row;
  logic [WIN_W-1:0] col_in_tile;
  logic [WIN_W-1:0] row_in_band;
  logic [COL_W-1:0] tile_column;

  // Effective configuration.
  logic [WIN_W-1:0] w;
  logic [CB_W-1:0]  wd;
  logic [ROW_W-1:0] ht;

  logic                    accept;
  logic                    band_ok, tile_ok, end_of_row, last_row;
  logic                    col_end, row_end, acc_en, tile_done, band_nl;
  logic [RGB_SUM_BITS-1:0] rgb_sum;

  // Accumulate stage: memory read data arrives here.
  logic                    s1_valid;
  logic                    s1_acc;
  bas_flags_t              s1_flags;
  logic [RGB_SUM_BITS-1:0] s1_sum;
  logic                    s1_zero;
  logic [COL_W-1:0]        s1_addr;
  logic                    s1_fwd;
  logic [SUM_W-1:0]        fwd_data;
  logic [SUM_W-1:0]        rd_data;
  logic [SUM_W-1:0]        base;
  logic [SUM_W-1:0]        new_sum;
  logic                    wr_en;

  logic [SUM_W-1:0] tile_sums [MAX_WIDTH];

  assign w  = WIN_W'(clamp_window(cfg.window_size, MAX_WINDOW));
  assign wd = CB_W'(clamp_width(cfg.image_width, MAX_WIDTH));
  assign ht = clamp_height(cfg.image_height);

  // Position checks for the pixel on the input.
  always_comb begin
    band_ok    = (RB_W'(ROW_W'(pixel_row - ROW_W'(row_in_band))) + RB_W'(w)) <= RB_W'(ht);
    tile_ok    = (CB_W'(COL_W'(pixel_column - COL_W'(col_in_tile))) + CB_W'(w)) <= wd;
    end_of_row = (CB_W'(pixel_column) + CB_W'(1)) >= wd;
    last_row   = (RB_W'(pixel_row) + RB_W'(1)) >= RB_W'(ht);
    col_end    = ((WIN_W + 1)'(col_in_tile) + (WIN_W + 1)'(1)) >= (WIN_W + 1)'(w);
    row_end    = ((WIN_W + 1)'(row_in_band) + (WIN_W + 1)'(1)) >= (WIN_W + 1)'(w);
    acc_en     = band_ok && tile_ok;
    tile_done  = acc_en && col_end && row_end;
    band_nl    = band_ok && end_of_row && row_end;
    rgb_sum    = RGB_SUM_BITS'(red) + RGB_SUM_BITS'(green) + RGB_SUM_BITS'(blue);
  end

  // Room is reserved for the item that the accumulate stage may still push.
  assign in_stall = ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(s1_valid)) >=
                    (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  // Raster counters.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      col_in_tile  <= '0;
      row_in_band  <= '0;
      tile_column  <= '0;
    end else if (accept) begin
      if (end_of_row) begin
        pixel_column <= '0;
        col_in_tile  <= '0;
        tile_column  <= '0;
        if (last_row) begin
          pixel_row   <= '0;
          row_in_band <= '0;
        end else begin
          pixel_row   <= pixel_row + ROW_W'(1);
          row_in_band <= row_end ? '0 : row_in_band + WIN_W'(1);
        end
      end else begin
        pixel_column <= pixel_column + COL_W'(1);
        if (col_end) begin
          col_in_tile <= '0;
          tile_column <= tile_column + COL_W'(1);
        end else begin
          col_in_tile <= col_in_tile + WIN_W'(1);
        end
      end
    end
  end

  // Only pixels that add or emit anything go on to the accumulate stage.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (acc_en || band_nl);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_acc            <= acc_en;
      s1_flags.has_char <= tile_done;
      s1_flags.has_nl   <= band_nl;
      s1_sum            <= rgb_sum;
      s1_zero           <= (row_in_band == '0) && (col_in_tile == '0);
      s1_addr           <= tile_column;
      // The write landing at this same edge is not yet in the read data.
      s1_fwd            <= wr_en && (s1_addr == tile_column);
      fwd_data          <= new_sum;
    end
  end

  // Tile sum memory: read at accept, written in the following cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tile_sums[s1_addr] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= tile_sums[tile_column];
    end
  end

  // The first pixel of each tile starts its sum from zero, so the memory
  // needs no clearing.
  always_comb begin
    if (s1_zero) begin
      base = '0;
    end else if (s1_fwd) begin
      base = fwd_data;
    end else begin
      base = rd_data;
    end
    new_sum = base + SUM_W'(s1_sum);
  end

  assign wr_en      = s1_valid && s1_acc;
  assign push       = s1_valid && (s1_flags.has_char || s1_flags.has_nl);
  assign push_flags = s1_flags;
  assign push_sum   = new_sum;

endmodule

`default_nettype wire

### hw/rtl/bas_fifo.sv
// ----------------------------------------------------------------------------
// Item queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_fifo #(
  parameter int WIDTH = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         not_empty,
  output logic [bas_pkg::Q_CNT_W-1:0]  count
);
  import bas_pkg::*;

  logic [WIDTH-1:0]   slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bas_back.sv
// ----------------------------------------------------------------------------
// Back part: divide and emit
// Divides a finished tile's sum by 3*window^2 one quotient bit per cycle,
// maps the grey level to a shade and emits the character and any newline.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_back #(
  parameter int MAX_WINDOW = 16,
  parameter int SUM_W      = $clog2(765 * MAX_WINDOW * MAX_WINDOW + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bas_pkg::WIN_BITS-1:0]    window_size,
  input  logic                            q_valid,
  input  bas_pkg::bas_flags_t             q_flags,
  input  logic [SUM_W-1:0]                q_sum,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bas_pkg::CHAR_BITS-1:0]   char_code,
  output logic                            last_of_run
);
  import bas_pkg::*;

  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W  = $clog2(3 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int EXT_W  = SUM_W + GREY_BITS;
  localparam int STEP_W = $clog2(GREY_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_CHAR = 2'd2;
  localparam logic [1:0] ST_NL   = 2'd3;

  logic [1:0]           state;
  logic                 has_nl;
  logic [SUM_W-1:0]     rem;
  logic [GREY_BITS-1:0] quo;
  logic [STEP_W-1:0]    step;
  logic [DIV_W-1:0]     divisor;

  logic [WIN_W-1:0]     w;
  logic [DIV_W-1:0]     div_load;
  logic [EXT_W-1:0]     trial;
  logic                 take;
  logic [SUM_W-1:0]     rem_next;
  logic [GREY_BITS-1:0] quo_next;

  assign w        = WIN_W'(clamp_window(window_size, MAX_WINDOW));
  assign div_load = DIV_W'(32'd3 * 32'(w) * 32'(w));

  // One restoring division step; the quotient never exceeds eight bits.
  always_comb begin
    trial    = EXT_W'(divisor) << step;
    take     = EXT_W'(rem) >= trial;
    rem_next = take ? SUM_W'(EXT_W'(rem) - trial) : rem;
    quo_next = quo;
    quo_next[step] = take;
  end

  assign pop       = (state == ST_IDLE) && q_valid;
  assign out_valid = (state == ST_CHAR) || (state == ST_NL);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            priority if (q_flags.has_char) state <= ST_DIV;
            else if (q_flags.has_nl)       state <= ST_NL;
            else                           state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (step == '0) state <= ST_CHAR;
        end
        ST_CHAR: begin
          if (!out_stall) state <= has_nl ? ST_NL : ST_IDLE;
        end
        ST_NL: begin
          if (!out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath and output registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          has_nl      <= q_flags.has_nl;
          rem         <= q_sum;
          quo         <= '0;
          step        <= STEP_W'(GREY_BITS - 1);
          divisor     <= div_load;
          char_code   <= NEWLINE;
          last_of_run <= 1'b1;
        end
      end
      ST_DIV: begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step - STEP_W'(1);
        if (step == '0) begin
          char_code   <= pick_shade(quo_next);
          last_of_run <= !has_nl;
        end
      end
      ST_CHAR: begin
        if (!out_stall && has_nl) begin
          char_code   <= NEWLINE;
          last_of_run <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/block_average_ascii_shader.sv
// ----------------------------------------------------------------------------
// Block average ASCII shader
// Averages RGB pixels over square tiles and emits one shade character per
// complete tile, with a newline after each complete band of tiles.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in raster order unless stalled. Each tile
// column's running sum lives in a one-read, one-write memory of MAX_WIDTH
// entries that is read when a pixel is taken and written back the next
// cycle, so a steady stream sees no bubbles. A finished tile or band end
// goes into a four-entry queue; the back part pops a queue entry only when
// idle, divides the sum by 3*window^2 (one quotient bit per cycle) and then
// presents the character and the newline, each held while the output
// stalls. Pixels are stalled only when entries arrive faster than the back
// part drains them and the queue fills. The tile sum memory needs no
// clearing pass after reset or after a register write: the first pixel of
// every tile starts its sum from zero.
`default_nettype none

module block_average_ascii_shader #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bas_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [bas_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [bas_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // Pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bas_pkg::PIX_BITS-1:0]        red,
  input  logic [bas_pkg::PIX_BITS-1:0]        green,
  input  logic [bas_pkg::PIX_BITS-1:0]        blue,
  // Character output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bas_pkg::CHAR_BITS-1:0]       char_code,
  output logic                                last_of_run
);
  import bas_pkg::*;

  localparam int SUM_W = $clog2(765 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int Q_W   = SUM_W + $bits(bas_flags_t);

  bas_cfg_t            cfg;
  logic                restart;
  logic                push;
  bas_flags_t          push_flags;
  logic [SUM_W-1:0]    push_sum;
  logic                pop;
  logic [Q_W-1:0]      pop_data;
  logic                q_valid;
  logic [Q_CNT_W-1:0]  q_count;
  bas_flags_t          q_flags;
  logic [SUM_W-1:0]    q_sum;

  assign pready  = 1'b1;
  assign q_flags = bas_flags_t'(pop_data[Q_W-1:SUM_W]);
  assign q_sum   = pop_data[SUM_W-1:0];

  bas_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .restart (restart)
  );

  bas_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .q_count    (q_count),
    .push       (push),
    .push_flags (push_flags),
    .push_sum   (push_sum)
  );

  bas_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_sum}),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid),
    .count     (q_count)
  );

  bas_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .window_size (cfg.window_size),
    .q_valid     (q_valid),
    .q_flags     (q_flags),
    .q_sum       (q_sum),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### hw/rtl/bas_checker.sv
// ----------------------------------------------------------------------------
// Output checker
// Watches the character output port for ordering and value rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_average_ascii_shader_macros.svh"

module bas_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [bas_pkg::CHAR_BITS-1:0]   char_code,
  input  logic                            last_of_run
);
  import bas_pkg::*;

  // A stalled item holds its contents.
  `BAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last_of_run), "stalled output item changed")

  // A newline always closes the run of its pixel.
  `BAS_ASSERT_IMPL(a_nl_last, out_valid && !last_of_run, char_code != NEWLINE, "newline not marked last")

  // A character that is not last is followed at once by its newline.
  `BAS_ASSERT_NEXT(a_nl_follows, out_valid && !out_stall && !last_of_run, out_valid && char_code == NEWLINE, "missing newline after tile")

  // Only shade characters and newlines leave the block.
  `BAS_ASSERT_IMPL(a_char_set, out_valid, char_code == SHADE_CHARS[0] || char_code == SHADE_CHARS[1] || char_code == SHADE_CHARS[2] || char_code == SHADE_CHARS[3] || char_code == SHADE_CHARS[4] || char_code == SHADE_CHARS[5] || char_code == SHADE_CHARS[6] || char_code == SHADE_CHARS[7] || char_code == SHADE_CHARS[8] || char_code == NEWLINE, "unexpected character code")

endmodule

bind block_average_ascii_shader bas_checker u_bas_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .char_code   (char_code),
  .last_of_run (last_of_run)
);

`default_nettype wire
